// ===== hdl/mpdb_pkg.sv =====
// ----------------------------------------------------------------------------
// mpdb_pkg
// Widths, stage record and arctangent table for the point distance and
// bearing pipeline.
// ----------------------------------------------------------------------------
package mpdb_pkg;

	localparam int COORD_WIDTH       = 16;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int TABLE_LEN         = 24;
	localparam int GUARD             = 16;

	localparam int DW    = COORD_WIDTH + 1;         // signed difference
	localparam int AW    = COORD_WIDTH;             // magnitude of difference
	localparam int SQW   = 2 * AW + 1;              // sum of squares
	localparam int QW    = AW + 1;                  // square root
	localparam int XW    = DW + GUARD + 3;          // CORDIC x / y
	localparam int ZW    = 27;                      // angle, pi / 2^24 units
	localparam int BW    = ZW + 1 - 9;              // bearing before wrap
	localparam int BRG_W = 17;

	localparam int ITERS = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
	localparam int DEPTH = (ITERS > QW) ? ITERS : QW;
	localparam int SW    = $clog2(((DEPTH > TABLE_LEN) ? DEPTH : TABLE_LEN) + 1);

	localparam int PI_UNITS = 1 << 24;

	typedef struct packed {
		logic                  vld;
		logic                  zero;
		logic signed [XW-1:0]  x;
		logic signed [XW-1:0]  y;
		logic signed [ZW-1:0]  z;
		logic [SQW-1:0]        rem;
		logic [QW-1:0]         root;
	} stage_t;

	// atan(2^-i) in units of pi / 2^24
	function automatic logic [ZW-1:0] atan_of(input logic [SW-1:0] i);
		logic [ZW-1:0] v;
		case (i)
			SW'(0):  v = ZW'(4194304);
			SW'(1):  v = ZW'(2476042);
			SW'(2):  v = ZW'(1308273);
			SW'(3):  v = ZW'(664100);
			SW'(4):  v = ZW'(333339);
			SW'(5):  v = ZW'(166832);
			SW'(6):  v = ZW'(83436);
			SW'(7):  v = ZW'(41721);
			SW'(8):  v = ZW'(20861);
			SW'(9):  v = ZW'(10430);
			SW'(10): v = ZW'(5215);
			SW'(11): v = ZW'(2608);
			SW'(12): v = ZW'(1304);
			SW'(13): v = ZW'(652);
			SW'(14): v = ZW'(326);
			SW'(15): v = ZW'(163);
			SW'(16): v = ZW'(81);
			SW'(17): v = ZW'(41);
			SW'(18): v = ZW'(20);
			SW'(19): v = ZW'(10);
			SW'(20): v = ZW'(5);
			SW'(21): v = ZW'(3);
			SW'(22): v = ZW'(1);
			SW'(23): v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/mirrored_point_distance_bearing.sv =====
// ----------------------------------------------------------------------------
// mirrored_point_distance_bearing
// Distance and bearing between two points, with optional x mirroring;
// square root and CORDIC vectoring run side by side in one pipeline.
// ----------------------------------------------------------------------------
//  channel   signals                              direction  handshake
//  input     start, busy, from_x/y, to_x/y        in         start & !busy
//  result    done, distance, bearing              out        done, one cycle
//  config    cfg_we, cfg_wdata (mirror_side)      in         cfg_we
//
//  One item per cycle; busy is always low. The stages are difference,
//  square and pre-rotation, sum of squares, then one stage per root bit /
//  micro-rotation, then rounding.
//  Reset clears mirror_side and all valid bits. The receiver cannot stall,
//  so the pipeline never holds.
// ----------------------------------------------------------------------------
module mirrored_point_distance_bearing (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    cfg_we,
	input  logic                                    cfg_wdata,
	input  logic signed [mpdb_pkg::COORD_WIDTH-1:0] from_x,
	input  logic signed [mpdb_pkg::COORD_WIDTH-1:0] from_y,
	input  logic signed [mpdb_pkg::COORD_WIDTH-1:0] to_x,
	input  logic signed [mpdb_pkg::COORD_WIDTH-1:0] to_y,
	output logic                                    done,
	output logic [mpdb_pkg::QW-1:0]                 distance,
	output logic signed [mpdb_pkg::BRG_W-1:0]       bearing
);
	import mpdb_pkg::*;

	logic                 mirror_q;

	logic                 vld_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;

	logic                 vld_s2;
	logic                 zero_s2;
	logic [2*AW-1:0]      sqx_s2;
	logic [2*AW-1:0]      sqy_s2;
	logic signed [XW-1:0] x_s2;
	logic signed [XW-1:0] y_s2;
	logic signed [ZW-1:0] z_s2;

	stage_t               st_s3;
	stage_t               stg [DEPTH+1];

	logic [DW-1:0]        adx;
	logic [DW-1:0]        ady;
	logic signed [XW-1:0] x0;
	logic signed [XW-1:0] y0;

	stage_t               fin;
	logic [QW-1:0]        dist_n;
	logic signed [ZW:0]   zb;
	logic signed [BW-1:0] bw;
	logic signed [BW-1:0] bw_w;

	logic                 done_q;
	logic [QW-1:0]        distance_q;
	logic [BRG_W-1:0]     bearing_q;

	assign busy     = 1'b0;
	assign done     = done_q;
	assign distance = distance_q;
	assign bearing  = signed'(bearing_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
		end else if (cfg_we) begin
			mirror_q <= cfg_wdata;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (mirror_q) begin
			dx_s1 <= DW'(from_x) - DW'(to_x);
		end else begin
			dx_s1 <= DW'(to_x) - DW'(from_x);
		end
		dy_s1 <= DW'(to_y) - DW'(from_y);
	end

	// stage 2: squares, CORDIC pre-rotation into the right half plane
	always_comb begin
		adx = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		ady = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		x0  = XW'(dx_s1) <<< GUARD;
		y0  = XW'(dy_s1) <<< GUARD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2  <= adx[AW-1:0] * adx[AW-1:0];
		sqy_s2  <= ady[AW-1:0] * ady[AW-1:0];
		zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
		if (dx_s1 < 0) begin
			x_s2 <= -x0;
			y_s2 <= -y0;
			z_s2 <= (dy_s1 >= 0) ? ZW'(PI_UNITS) : -ZW'(PI_UNITS);
		end else begin
			x_s2 <= x0;
			y_s2 <= y0;
			z_s2 <= '0;
		end
	end

	// stage 3: sum of squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s3 <= '0;
		end else begin
			st_s3.vld  <= vld_s2;
			st_s3.zero <= zero_s2;
			st_s3.x    <= x_s2;
			st_s3.y    <= y_s2;
			st_s3.z    <= z_s2;
			st_s3.rem  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			st_s3.root <= '0;
		end
	end

	assign stg[0] = st_s3;

	for (genvar k = 0; k < DEPTH; k++) begin : g_step
		mpdb_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (SW'(k)),
			.d      (stg[k]),
			.q      (stg[k+1])
		);
	end

	// output: round root to nearest, round and wrap the angle
	always_comb begin
		fin    = stg[DEPTH];
		dist_n = fin.root + QW'(fin.rem > SQW'(fin.root));
		zb     = (ZW + 1)'(fin.z) + (ZW + 1)'(256);
		bw     = BW'(zb >>> 9);
		bw_w   = bw;
		if (bw <= -BW'(32768)) begin
			bw_w = BW'(bw + BW'(65536));
		end else if (bw > BW'(32768)) begin
			bw_w = BW'(bw - BW'(65536));
		end
		if (fin.zero) begin
			dist_n = '0;
			bw_w   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		distance_q <= dist_n;
		bearing_q  <= bw_w[BRG_W-1:0];
	end

endmodule

// ===== hdl/mpdb_step.sv =====
// ----------------------------------------------------------------------------
// mpdb_step
// One pipeline stage by tied-off index: CORDIC vectoring micro-rotation
// while step < ITERS, one digit-by-digit square root bit while step < QW.
// ----------------------------------------------------------------------------
module mpdb_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mpdb_pkg::SW-1:0]   step,
	input  mpdb_pkg::stage_t          d,
	output mpdb_pkg::stage_t          q
);
	import mpdb_pkg::*;

	stage_t               nxt;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [ZW-1:0] ang;
	logic [SW-1:0]        b;
	logic [SQW:0]         trial;
	logic [SQW:0]         root_ext;
	logic [SQW:0]         one;

	always_comb begin
		nxt      = d;
		xs       = d.x >>> step;
		ys       = d.y >>> step;
		ang      = signed'(atan_of(step));
		b        = SW'(QW - 1) - step;
		root_ext = {{(SQW + 1 - QW){1'b0}}, d.root};
		one      = (SQW + 1)'(1);
		trial    = ((root_ext << b) << 1) + (one << {b, 1'b0});
		if (step < SW'(ITERS)) begin
			if (d.y > 0) begin
				nxt.x = d.x + ys;
				nxt.y = d.y - xs;
				nxt.z = d.z + ang;
			end else begin
				nxt.x = d.x - ys;
				nxt.y = d.y + xs;
				nxt.z = d.z - ang;
			end
		end
		if (step < SW'(QW)) begin
			if ({1'b0, d.rem} >= trial) begin
				nxt.rem  = d.rem - trial[SQW-1:0];
				nxt.root = d.root | (QW'(1) << b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= nxt;
		end
	end

endmodule
